/* src/bst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bst_pkg: shared constants, types and angle table
// Widths, CORDIC stage count and the arctangent table for the tracker.
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam int ANGLE_BITS      = 16;   // 2^ANGLE_BITS units per full turn
  localparam int ATAN_ITERATIONS = 16;
  localparam int TABLE_LEN       = 24;
  localparam int STAGES          = (ATAN_ITERATIONS > TABLE_LEN) ? TABLE_LEN
                                                                 : ATAN_ITERATIONS;
  localparam int IDX_W           = $clog2(TABLE_LEN);
  localparam int GUARD_SHIFT     = 24;
  localparam int FIELD_W         = 16;
  localparam int STEP_W          = 15;
  localparam int ACC_W           = 32;
  // 16-bit input scaled by 2^24, half-turn negate and CORDIC gain (~1.65)
  localparam int XW              = FIELD_W + GUARD_SHIFT + 3;
  // signed step width: holds +/- half turn and +/- max_step with margin
  localparam int DW              = ((ANGLE_BITS + 1 > FIELD_W) ? ANGLE_BITS + 1
                                                               : FIELD_W) + 1;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 16;

  localparam logic [STEP_W-1:0]     MAX_STEP_RST     = STEP_W'(910);
  localparam logic [FIELD_W-1:0]    MOUNT_OFFSET_RST = FIELD_W'(16384);
  localparam logic [ACC_W-1:0]      ACC_HALF_TURN    = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_STEP     = 1'b0,
    REG_MOUNT_OFFSET = 1'b1
  } cfg_reg_t;

  // data handed from one CORDIC cell to the next
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [ACC_W-1:0]     acc;
    logic                 zero;   // dx = dy = 0, angle forced to zero
  } cell_data_t;

  // atan(2^-i) in 32-bit turn units
  function automatic logic [ACC_W-1:0] atan_turn(input logic [IDX_W-1:0] idx);
    logic [ACC_W-1:0] t;
    unique case (idx)
      5'd0:    t = 32'h2000_0000;
      5'd1:    t = 32'h12E4_051E;
      5'd2:    t = 32'h09FB_385B;
      5'd3:    t = 32'h0511_11D4;
      5'd4:    t = 32'h028B_0D43;
      5'd5:    t = 32'h0145_D7E1;
      5'd6:    t = 32'h00A2_F61E;
      5'd7:    t = 32'h0051_7C55;
      5'd8:    t = 32'h0028_BE53;
      5'd9:    t = 32'h0014_5F2F;
      5'd10:   t = 32'h000A_2F98;
      5'd11:   t = 32'h0005_17CC;
      5'd12:   t = 32'h0002_8BE6;
      5'd13:   t = 32'h0001_45F3;
      5'd14:   t = 32'h0000_A2FA;
      5'd15:   t = 32'h0000_517D;
      5'd16:   t = 32'h0000_28BE;
      5'd17:   t = 32'h0000_145F;
      5'd18:   t = 32'h0000_0A30;
      5'd19:   t = 32'h0000_0518;
      5'd20:   t = 32'h0000_028C;
      5'd21:   t = 32'h0000_0146;
      5'd22:   t = 32'h0000_00A3;
      5'd23:   t = 32'h0000_0051;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

/* src/bst_cordic_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bst_cordic_cell: one vectoring CORDIC iteration
// Rotates toward y = 0 by atan(2^-idx) and registers the result for the next cell.
// ----------------------------------------------------------------------------
module bst_cordic_cell
  import bst_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic [IDX_W-1:0] stage_idx,
  input  wire logic             vld_in,
  input  wire cell_data_t       d_in,
  output logic                  vld_out,
  output cell_data_t            d_out
);

  logic                 vld_r;
  cell_data_t           d_r;
  cell_data_t           d_nxt;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic [ACC_W-1:0]     ang;

  always_comb begin
    xs  = d_in.x >>> stage_idx;   // floor shift
    ys  = d_in.y >>> stage_idx;
    ang = atan_turn(stage_idx);
    d_nxt.zero = d_in.zero;
    if (!d_in.y[XW-1]) begin
      d_nxt.x   = d_in.x + ys;
      d_nxt.y   = d_in.y - xs;
      d_nxt.acc = d_in.acc + ang;
    end else begin
      d_nxt.x   = d_in.x - ys;
      d_nxt.y   = d_in.y + xs;
      d_nxt.acc = d_in.acc - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= d_nxt;
    end
  end

  assign vld_out = vld_r;
  assign d_out   = d_r;

endmodule
`default_nettype wire

/* src/bst_slew.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bst_slew: heading update and result register
// Wraps bearing minus heading, clamps to max_step, updates the heading.
// ----------------------------------------------------------------------------
module bst_slew
  import bst_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      adv,
  input  wire logic                      bvld,
  input  wire logic [ANGLE_BITS-1:0]     bearing,
  input  wire logic [STEP_W-1:0]         max_step,
  input  wire logic                      out_stall,
  output logic                           out_valid,
  output logic [FIELD_W-1:0]             out_heading,
  output logic [FIELD_W-1:0]             out_bearing,
  output logic signed [FIELD_W-1:0]      out_step_taken
);

  localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(2 ** (ANGLE_BITS - 1));
  localparam logic signed [DW-1:0]  FULL_TURN = DW'(2 ** ANGLE_BITS);

  logic [ANGLE_BITS-1:0]        heading_r;
  logic [ANGLE_BITS-1:0]        heading_nxt;
  logic [ANGLE_BITS-1:0]        diff;
  logic signed [DW-1:0]         wrapped;
  logic signed [DW-1:0]         lim;
  logic signed [DW-1:0]         delta;
  logic                         ld;
  logic                         out_valid_r;
  logic [FIELD_W-1:0]           out_heading_r;
  logic [FIELD_W-1:0]           out_bearing_r;
  logic signed [FIELD_W-1:0]    out_step_r;

  assign ld = adv && bvld;

  always_comb begin
    diff    = bearing - heading_r;
    // exact half turn stays positive
    wrapped = (diff > HALF_TURN) ? signed'(DW'(diff)) - FULL_TURN
                                 : signed'(DW'(diff));
    lim     = signed'(DW'(max_step));
    priority if (wrapped > lim) begin
      delta = lim;
    end else if (wrapped < -lim) begin
      delta = -lim;
    end else begin
      delta = wrapped;
    end
    heading_nxt = heading_r + delta[ANGLE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= bvld;
      if (bvld) begin
        heading_r <= heading_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_heading_r <= FIELD_W'(heading_nxt);
      out_bearing_r <= FIELD_W'(bearing);
      out_step_r    <= FIELD_W'(delta);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_heading    = out_heading_r;
  assign out_bearing    = out_bearing_r;
  assign out_step_taken = out_step_r;

  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid after reset");
  a_heading_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ld |=> $stable(heading_r))
    else $error("heading moved without an update");
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_heading_r)
      && $stable(heading_r))
    else $error("stalled result or heading changed");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && !bvld |=> !out_valid_r)
    else $error("result repeated");

endmodule
`default_nettype wire

/* src/bearing_slew_tracker_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bearing_slew_tracker_unit: slew-rate limited bearing tracker
// Pipeline: input stage, 16 CORDIC cells, bearing stage, then the result
//   register.
// Throughput: one request per cycle; the cell chain and the heading update
//   advance together and hold only while a result waits under out_stall.
// Reset: valids cleared, heading 0, max_step 910, mount_offset 16384.
// ----------------------------------------------------------------------------
module bearing_slew_tracker_unit
  import bst_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // request channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [FIELD_W-1:0]   in_target_dx,
  input  wire logic signed [FIELD_W-1:0]   in_target_dy,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [FIELD_W-1:0]               out_heading,
  output logic [FIELD_W-1:0]               out_bearing,
  output logic signed [FIELD_W-1:0]        out_step_taken,
  // configuration
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_wdata
);

  // half an output LSB in accumulator units, for rounding
  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (ACC_W - 1 - ANGLE_BITS);

  // --------------------------------------------------------------------------
  // Config registers: written by the user only while idle; not enforced.
  // --------------------------------------------------------------------------
  logic [STEP_W-1:0]  max_step_r;
  logic [FIELD_W-1:0] mount_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_step_r     <= MAX_STEP_RST;
      mount_offset_r <= MOUNT_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAX_STEP:     max_step_r     <= cfg_wdata[STEP_W-1:0];
        REG_MOUNT_OFFSET: mount_offset_r <= cfg_wdata[FIELD_W-1:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Global advance: the whole chain moves unless the result register is
  // full and the consumer stalls it. No flow control inside the chain.
  // --------------------------------------------------------------------------
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // --------------------------------------------------------------------------
  // Input stage: scale by 2^24 and fold the left half-plane onto the right
  // (negate x and y, start the angle at a half turn).
  // --------------------------------------------------------------------------
  logic                 prep_vld_r;
  cell_data_t           prep_r;
  cell_data_t           prep_nxt;
  logic signed [XW-1:0] dx_w;
  logic signed [XW-1:0] dy_w;

  always_comb begin
    dx_w = XW'(in_target_dx) <<< GUARD_SHIFT;
    dy_w = XW'(in_target_dy) <<< GUARD_SHIFT;
    prep_nxt.zero = (in_target_dx == '0) && (in_target_dy == '0);
    if (in_target_dx[FIELD_W-1]) begin
      prep_nxt.x   = -dx_w;
      prep_nxt.y   = -dy_w;
      prep_nxt.acc = ACC_HALF_TURN;
    end else begin
      prep_nxt.x   = dx_w;
      prep_nxt.y   = dy_w;
      prep_nxt.acc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_vld_r <= 1'b0;
    end else if (adv) begin
      prep_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prep_r <= prep_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // CORDIC chain: cell k does iteration k, handing on each cycle adv is high.
  // --------------------------------------------------------------------------
  cell_data_t stg_d [STAGES+1];
  logic       stg_v [STAGES+1];

  assign stg_d[0] = prep_r;
  assign stg_v[0] = prep_vld_r;

  for (genvar k = 0; k < STAGES; k++) begin : g_cell
    bst_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .stage_idx (IDX_W'(k)),
      .vld_in    (stg_v[k]),
      .d_in      (stg_d[k]),
      .vld_out   (stg_v[k+1]),
      .d_out     (stg_d[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Bearing stage: round the angle to ANGLE_BITS, zero offset gives angle
  // zero, then add the mounting offset modulo a full turn.
  // --------------------------------------------------------------------------
  logic                  brg_vld_r;
  logic [ANGLE_BITS-1:0] brg_r;
  logic [ACC_W-1:0]      acc_rnd;
  logic [ANGLE_BITS-1:0] atan_ang;
  logic [ANGLE_BITS-1:0] brg_nxt;

  always_comb begin
    acc_rnd  = stg_d[STAGES].acc + RND_HALF;
    atan_ang = stg_d[STAGES].zero ? '0 : acc_rnd[ACC_W-1 -: ANGLE_BITS];
    brg_nxt  = atan_ang + ANGLE_BITS'(mount_offset_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brg_vld_r <= 1'b0;
    end else if (adv) begin
      brg_vld_r <= stg_v[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      brg_r <= brg_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Heading update and result register.
  // --------------------------------------------------------------------------
  bst_slew u_slew (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .bvld           (brg_vld_r),
    .bearing        (brg_r),
    .max_step       (max_step_r),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_heading    (out_heading),
    .out_bearing    (out_bearing),
    .out_step_taken (out_step_taken)
  );

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for bearing_slew_tracker_unit
// Target offsets are streamed in from a queue and the heading, bearing and
// applied step that come back are compared to an in-bench slew tracker.
// The bench runs its own vectoring atan2, steps through several register
// settings and throws random idles and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import bst_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no traffic at all
  localparam int DRAIN_CYCLES   = 40;    // longer than the pipeline latency
  localparam int CORDIC_STEPS   = (ATAN_ITERATIONS > 24) ? 24 : ATAN_ITERATIONS;

  typedef struct packed {
    logic signed [FIELD_W-1:0] dx;
    logic signed [FIELD_W-1:0] dy;
  } target_t;

  typedef struct packed {
    logic [FIELD_W-1:0]        heading;
    logic [FIELD_W-1:0]        bearing;
    logic signed [FIELD_W-1:0] step_taken;
  } track_result_t;

  // --------------------------------------------------------------------------
  // clock, reset and DUT ports (all inputs start at known values)
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid     = 1'b0;
  logic                      in_stall;
  logic signed [FIELD_W-1:0] in_target_dx = '0;
  logic signed [FIELD_W-1:0] in_target_dy = '0;

  logic                      out_valid;
  logic                      out_stall    = 1'b0;
  logic [FIELD_W-1:0]        out_heading;
  logic [FIELD_W-1:0]        out_bearing;
  logic signed [FIELD_W-1:0] out_step_taken;

  logic                      cfg_we       = 1'b0;
  cfg_reg_t                  cfg_index    = REG_MAX_STEP;
  logic [CFG_DATA_W-1:0]     cfg_wdata    = '0;

  always #5 clk = ~clk;

  bearing_slew_tracker_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_target_dx   (in_target_dx),
    .in_target_dy   (in_target_dy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_heading    (out_heading),
    .out_bearing    (out_bearing),
    .out_step_taken (out_step_taken),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // bench-side copy of the tracker: registers and heading
  // --------------------------------------------------------------------------
  logic [STEP_W-1:0]  slew_limit      = 15'd910;
  logic [FIELD_W-1:0] mount_angle     = 16'd16384;
  logic [FIELD_W-1:0] tracked_heading = '0;

  // atan(2^-i), 2^32 units per turn
  logic [31:0] atan_lut [24] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
  };

  // Vectoring CORDIC: angle of (dx, dy) in 16-bit turn units. Left half-plane
  // vectors are flipped through the origin first and start at a half turn.
  // longint is ample: 2^39 input times the ~1.65 CORDIC gain.
  function automatic logic [FIELD_W-1:0] target_angle(input logic signed [FIELD_W-1:0] dx,
                                                       input logic signed [FIELD_W-1:0] dy);
    longint      x;
    longint      y;
    longint      xs;
    longint      ys;
    logic [31:0] acc;
    if (dx == 0 && dy == 0)
      return '0;
    x   = longint'(dx) <<< GUARD_SHIFT;
    y   = longint'(dy) <<< GUARD_SHIFT;
    acc = '0;
    if (x < 0) begin
      x   = -x;
      y   = -y;
      acc = 32'h8000_0000;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;   // arithmetic shift floors toward minus infinity
      ys = y >>> i;
      if (y >= 0) begin
        x   = x + ys;
        y   = y - xs;
        acc = acc + atan_lut[i];
      end else begin
        x   = x - ys;
        y   = y + xs;
        acc = acc - atan_lut[i];
      end
    end
    acc = acc + (32'd1 << (31 - FIELD_W));  // round to nearest 16-bit unit
    return acc[31 -: FIELD_W];
  endfunction

  // One heading update: wrap the error into +/- half turn (a tie goes
  // positive), clamp to the slew limit, then advance the heading.
  function automatic track_result_t slew_toward(input target_t tgt);
    track_result_t      res;
    logic [FIELD_W-1:0] brg;
    logic [FIELD_W-1:0] err;
    int                 delta;
    brg   = target_angle(tgt.dx, tgt.dy) + mount_angle;
    err   = brg - tracked_heading;
    delta = (err > 16'h8000) ? int'(err) - 65536 : int'(err);
    if (delta > int'(slew_limit))
      delta = int'(slew_limit);
    else if (delta < -int'(slew_limit))
      delta = -int'(slew_limit);
    tracked_heading = tracked_heading + delta[FIELD_W-1:0];
    res.heading     = tracked_heading;
    res.bearing     = brg;
    res.step_taken  = delta[FIELD_W-1:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // bookkeeping
  // --------------------------------------------------------------------------
  target_t       pending_targets[$];
  track_result_t expected_tracks[$];
  int            errors          = 0;
  int            requests_sent   = 0;
  int            results_checked = 0;
  int            reg_writes      = 0;
  int            cycle_count     = 0;
  int            quiet_cycles    = 0;

  // Idles and stalls are dropped for the last quarter of each cycle_count window,
  // which gives back-to-back streaming stretches between the choppy ones.
  wire quiet_stretch = (cycle_count % 2048) >= 1536;

  // --------------------------------------------------------------------------
  // request driver: predicts at acceptance, payload held while stalled
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_tracks.push_back(slew_toward('{in_target_dx, in_target_dy}));
        requests_sent++;
      end
      // only move on when the port is free or its request just went through
      if (!in_valid || !in_stall) begin
        if (pending_targets.size() != 0 &&
            (quiet_stretch || $urandom_range(99) >= 12)) begin
          target_t nxt;
          nxt = pending_targets.pop_front();
          in_valid     <= 1'b1;
          in_target_dx <= nxt.dx;
          in_target_dy <= nxt.dy;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result monitor: random back-pressure, in-order field compare
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_tracks.size() == 0) begin
          $error("unexpected result: heading %0d bearing %0d step %0d",
                 out_heading, out_bearing, out_step_taken);
          errors++;
        end else begin
          track_result_t want;
          want = expected_tracks.pop_front();
          if (out_heading !== want.heading) begin
            $error("heading mismatch: expected %0d, got %0d", want.heading, out_heading);
            errors++;
          end
          if (out_bearing !== want.bearing) begin
            $error("bearing mismatch: expected %0d, got %0d", want.bearing, out_bearing);
            errors++;
          end
          if (out_step_taken !== want.step_taken) begin
            $error("step_taken mismatch: expected %0d, got %0d",
                   want.step_taken, out_step_taken);
            errors++;
          end
          results_checked++;
        end
      end
      out_stall <= !quiet_stretch && ($urandom_range(99) < 12);
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: any accepted request, result, register write or reset resets it
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles, %0d results outstanding",
               quiet_cycles, expected_tracks.size());
      $display("** bearing_slew_tracker_unit: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  logic signed [FIELD_W-1:0] corner_vals [6] = '{
    -16'sd32767 - 16'sd1, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767
  };

  // dx in the upper half, dy in the lower
  logic [31:0] directed_pairs [18] = '{
    32'h0000_0000,  // zero offset: bearing is the mount angle alone
    32'h7FFF_0000, 32'h8000_0000, 32'h0000_7FFF, 32'h0000_8000,
    32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0001_0001, 32'h0001_FFFF,
    32'hFFFF_0001, 32'h7FFF_7FFF, 32'h8000_8000, 32'h8000_7FFF,
    32'h7FFF_8000, 32'h8000_0001, 32'h8000_FFFF, 32'h0000_0001,
    32'h0001_0000
  };

  // registers only change with the pipe empty
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_MAX_STEP)
      slew_limit = data[STEP_W-1:0];   // top bit is dropped by the register
    else
      mount_angle = data;
    reg_writes++;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_targets.size() != 0 || in_valid || expected_tracks.size() != 0);
  endtask

  // Random targets, often held for a run of updates so the heading has time
  // to slew in and settle on the bearing; the rest are one-off jumps.
  task automatic queue_random(input int count);
    target_t tgt;
    int      pick;
    int      run;
    while (count > 0) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        tgt.dx = FIELD_W'($urandom);
        tgt.dy = FIELD_W'($urandom);
      end else if (pick < 60) begin
        tgt.dx = FIELD_W'($urandom_range(16) - 8);
        tgt.dy = FIELD_W'($urandom_range(16) - 8);
      end else if (pick < 75) begin
        // on an axis or a diagonal
        tgt.dx = FIELD_W'($urandom);
        case ($urandom_range(3))
          0:       tgt.dy = '0;
          1:       begin tgt.dy = tgt.dx; tgt.dx = '0; end
          2:       tgt.dy = tgt.dx;
          default: tgt.dy = -tgt.dx;
        endcase
      end else begin
        tgt.dx = corner_vals[$urandom_range(5)];
        tgt.dy = corner_vals[$urandom_range(5)];
      end
      run = ($urandom_range(3) == 0) ? $urandom_range(24, 2) : 1;
      for (int k = 0; k < run && count > 0; k++) begin
        pending_targets.push_back(tgt);
        count--;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: field corners and every quadrant
    foreach (directed_pairs[k])
      pending_targets.push_back(target_t'(directed_pairs[k]));
    queue_random(180);
    drain();

    // widest slew (write with bit 15 set to see it dropped), no mount angle.
    // Two targets on +x settle the heading at zero, then -x lands exactly
    // half a turn away: the tie has to go positive.
    write_reg(REG_MAX_STEP, 16'hFFFF);
    write_reg(REG_MOUNT_OFFSET, 16'h0000);
    pending_targets.push_back(32'h0001_0000);
    pending_targets.push_back(32'h0001_0000);
    pending_targets.push_back(32'hFFFF_0000);
    pending_targets.push_back(32'h0000_0000);
    queue_random(300);
    drain();

    // frozen heading, largest mount angle
    write_reg(REG_MAX_STEP, 16'h0000);
    write_reg(REG_MOUNT_OFFSET, 16'hFFFF);
    queue_random(150);
    drain();

    // crawl by one unit per update, mount at half a turn
    write_reg(REG_MAX_STEP, 16'h0001);
    write_reg(REG_MOUNT_OFFSET, 16'h8000);
    queue_random(100);
    drain();

    // arbitrary settings
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_MAX_STEP, CFG_DATA_W'($urandom));
      write_reg(REG_MOUNT_OFFSET, CFG_DATA_W'($urandom));
      queue_random(190);
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_tracks.size() != 0) begin
      $error("%0d expected results never arrived", expected_tracks.size());
      errors++;
    end

    $display("Run: %0d target updates sent, %0d results checked, %0d register writes,",
             requests_sent, results_checked, reg_writes);
    $display("  covering zero/max slew, mount corners and the half-turn tie; %0d errors.",
             errors);
    if (errors == 0) begin
      $display("** bearing_slew_tracker_unit: PASSED **");
    end else begin
      $display("** bearing_slew_tracker_unit: FAILED **");
    end
    $finish;
  end

endmodule
